### hw/rtl/imh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and constants of the indexed min-heap core.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int CAPACITY    = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int NB_W        = IDX_W + 2;
   localparam int KEY_W       = 32;
   localparam int BUILD_START = (CAPACITY - 1) / 2;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_BUILD  = 2'd1;
   localparam logic [1:0] ACT_INSERT = 2'd2;
   localparam logic [1:0] ACT_REMOVE = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_PRESENT = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_LOADREF = 3'd4;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]              action;
      logic [5:0]              item_id;
      logic signed [KEY_W-1:0] key;
   } imh_req_type;

   typedef struct packed {
      logic [5:0]              top_id;
      logic signed [KEY_W-1:0] top_key;
      logic                    empty_res;
      logic [6:0]              count;
      logic [2:0]              status;
   } imh_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_R_POS,
      S_U_RD,
      S_U_PID,
      S_U_PKEY,
      S_U_END,
      S_P_RD,
      S_B_FILL,
      S_D_SLOT,
      S_D_XID,
      S_D_KEY,
      S_D_L,
      S_D_LID,
      S_D_LKEY,
      S_D_RID,
      S_D_RKEY,
      S_D_DEC,
      S_D_END,
      S_TOP,
      S_T_ID,
      S_T_KEY,
      S_DONE
   } imh_state_type;

endpackage

### hw/rtl/indexed_min_heap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_core
// Indexed binary min-heap over CAPACITY ids with remove-by-id.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid / req_stall / req_data) carries one item: an
//    action (load key, build all, insert id, remove id), an id and a key.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one item
//    per request: top id and key, count, empty flag and status.
//  - One item is worked on at a time; req_stall is high while it runs.
//  - State lives in three RAMs with registered read data (keys, heap slots, slot of
//    each id); presence bits and the fill count are flip-flops.
//  - A load or an error goes straight to the root read-back; insert climbs
//    level by level (up to 6 levels); remove climbs to the root, then sifts
//    down level by level from the root; build fills the slot and position
//    tables for all 64 ids, then runs 32 sift-downs.
//    Each level costs a slot read then a key read.
//  - Reset clears presence bits and the count; RAM contents need no clearing.
//  - A stalled result sits in the output register; the core finishes the
//    next step only once that register is free.
// ----------------------------------------------------------------------------
module indexed_min_heap_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  imh_pkg::imh_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output imh_pkg::imh_rsp_type rsp_data
);

   import imh_pkg::*;

   imh_state_type state_ff, state_in;

   logic [1:0]              act_ff, act_in;
   logic [2:0]              st_ff, st_in;
   logic [IDX_W-1:0]        s_ff, s_in;          // current slot
   logic [IDX_W-1:0]        x_id_ff, x_id_in;    // carried element
   logic signed [KEY_W-1:0] x_key_ff, x_key_in;
   logic [IDX_W-1:0]        c_id_ff, c_id_in;    // neighbor id
   logic [IDX_W-1:0]        m_ff, m_in;          // best slot in sift-down
   logic [IDX_W-1:0]        m_id_ff, m_id_in;
   logic signed [KEY_W-1:0] m_key_ff, m_key_in;
   logic [IDX_W-1:0]        bidx_ff, bidx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CAPACITY-1:0]     pres_ff, pres_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   imh_rsp_type             rsp_ff, rsp_in;

   logic                    key_we, slot_we, pos_we;
   logic [IDX_W-1:0]        key_wa, slot_wa, pos_wa;
   logic [KEY_W-1:0]        key_wd;
   logic [IDX_W-1:0]        slot_wd, pos_wd;
   logic [IDX_W-1:0]        key_ra, slot_ra, pos_ra;
   logic [KEY_W-1:0]        key_rd;
   logic [IDX_W-1:0]        slot_rd, pos_rd;

   logic                    accept;
   logic                    id_ok;
   logic [IDX_W-1:0]        parent;
   logic [NB_W-1:0]         lc, rc, cnt_ext;
   logic signed [KEY_W-1:0] key_rd_s;

   imh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(key_ra), .rd_data(key_rd)
   );

   imh_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
      .rd_addr(slot_ra), .rd_data(slot_rd)
   );

   imh_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_pos_ram (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_wd),
      .rd_addr(pos_ra), .rd_data(pos_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign id_ok    = ({1'b0, req_data.item_id} < CNT_W'(CAPACITY));
   assign parent   = IDX_W'((s_ff - 1'b1) >> 1);
   assign lc       = NB_W'({s_ff, 1'b1});
   assign rc       = lc + 1'b1;
   assign cnt_ext  = NB_W'(cnt_ff);
   assign key_rd_s = $signed(key_rd);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      st_in        = st_ff;
      s_in         = s_ff;
      x_id_in      = x_id_ff;
      x_key_in     = x_key_ff;
      c_id_in      = c_id_ff;
      m_in         = m_ff;
      m_id_in      = m_id_ff;
      m_key_in     = m_key_ff;
      bidx_in      = bidx_ff;
      cnt_in       = cnt_ff;
      pres_in      = pres_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      key_we  = 1'b0;  key_wa  = x_id_ff;  key_wd  = req_data.key;
      slot_we = 1'b0;  slot_wa = s_ff;     slot_wd = x_id_ff;
      pos_we  = 1'b0;  pos_wa  = x_id_ff;  pos_wd  = s_ff;
      key_ra  = c_id_ff;
      slot_ra = s_ff;
      pos_ra  = req_data.item_id;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in   = req_data.action;
               st_in    = ST_OK;
               x_id_in  = req_data.item_id;
               x_key_in = req_data.key;
               state_in = S_TOP;
               unique case (req_data.action)
                  ACT_LOAD: begin
                     if (!id_ok) begin
                        st_in = ST_ABSENT;
                     end else if (pres_ff[req_data.item_id]) begin
                        st_in = ST_LOADREF;
                     end else begin
                        key_we = 1'b1;
                        key_wa = req_data.item_id;
                     end
                  end
                  ACT_BUILD: begin
                     bidx_in  = '0;
                     state_in = S_B_FILL;
                  end
                  ACT_INSERT: begin
                     if (!id_ok) begin
                        st_in = ST_ABSENT;
                     end else if (cnt_ff >= CNT_W'(CAPACITY)) begin
                        st_in = ST_FULL;
                     end else if (pres_ff[req_data.item_id]) begin
                        st_in = ST_PRESENT;
                     end else begin
                        key_we   = 1'b1;
                        key_wa   = req_data.item_id;
                        pres_in[req_data.item_id] = 1'b1;
                        s_in     = IDX_W'(cnt_ff);
                        cnt_in   = cnt_ff + 1'b1;
                        state_in = S_U_RD;
                     end
                  end
                  ACT_REMOVE: begin
                     if (!id_ok || !pres_ff[req_data.item_id] || cnt_ff == '0) begin
                        st_in = ST_ABSENT;
                     end else begin
                        key_we   = 1'b1;
                        key_wa   = req_data.item_id;
                        key_wd   = KEY_MIN;
                        x_key_in = KEY_MIN;
                        pres_in[req_data.item_id] = 1'b0;
                        state_in = S_R_POS;
                     end
                  end
                  default: state_in = S_TOP;
               endcase
            end
         end
         S_R_POS: begin
            s_in     = pos_rd;
            state_in = S_U_RD;
         end
         // sift up: parents move down until the carried element settles
         S_U_RD: begin
            if (s_ff == '0) begin
               slot_we  = 1'b1;
               pos_we   = 1'b1;
               state_in = S_U_END;
            end else begin
               slot_ra  = parent;
               state_in = S_U_PID;
            end
         end
         S_U_PID: begin
            c_id_in  = slot_rd;
            key_ra   = slot_rd;
            state_in = S_U_PKEY;
         end
         S_U_PKEY: begin
            slot_we = 1'b1;
            pos_we  = 1'b1;
            if (act_ff == ACT_REMOVE || x_key_ff < key_rd_s) begin
               slot_wd  = c_id_ff;
               pos_wa   = c_id_ff;
               s_in     = parent;
               state_in = S_U_RD;
            end else begin
               state_in = S_U_END;
            end
         end
         S_U_END: begin
            state_in = S_TOP;
            if (act_ff == ACT_REMOVE) begin
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff > CNT_W'(1)) begin
                  slot_ra  = IDX_W'(cnt_ff - 1'b1);
                  state_in = S_P_RD;
               end
            end
         end
         S_P_RD: begin
            x_id_in  = slot_rd;
            key_ra   = slot_rd;
            s_in     = '0;
            state_in = S_D_KEY;
         end
         S_B_FILL: begin
            slot_we = 1'b1;
            slot_wa = bidx_ff;
            slot_wd = bidx_ff;
            pos_we  = 1'b1;
            pos_wa  = bidx_ff;
            pos_wd  = bidx_ff;
            if (bidx_ff == IDX_W'(CAPACITY - 1)) begin
               cnt_in   = CNT_W'(CAPACITY);
               pres_in  = '1;
               bidx_in  = IDX_W'(BUILD_START);
               s_in     = IDX_W'(BUILD_START);
               state_in = S_D_SLOT;
            end else begin
               bidx_in = bidx_ff + 1'b1;
            end
         end
         // sift down
         S_D_SLOT: begin
            state_in = S_D_XID;
         end
         S_D_XID: begin
            x_id_in  = slot_rd;
            key_ra   = slot_rd;
            state_in = S_D_KEY;
         end
         S_D_KEY: begin
            x_key_in = key_rd_s;
            state_in = S_D_L;
         end
         S_D_L: begin
            if (lc >= cnt_ext) begin
               slot_we  = 1'b1;
               pos_we   = 1'b1;
               state_in = S_D_END;
            end else begin
               slot_ra  = lc[IDX_W-1:0];
               state_in = S_D_LID;
            end
         end
         S_D_LID: begin
            c_id_in  = slot_rd;
            key_ra   = slot_rd;
            state_in = S_D_LKEY;
         end
         S_D_LKEY: begin
            if (key_rd_s < x_key_ff) begin
               m_in     = lc[IDX_W-1:0];
               m_id_in  = c_id_ff;
               m_key_in = key_rd_s;
            end else begin
               m_in     = s_ff;
               m_key_in = x_key_ff;
            end
            if (rc < cnt_ext) begin
               slot_ra  = rc[IDX_W-1:0];
               state_in = S_D_RID;
            end else begin
               state_in = S_D_DEC;
            end
         end
         S_D_RID: begin
            c_id_in  = slot_rd;
            key_ra   = slot_rd;
            state_in = S_D_RKEY;
         end
         S_D_RKEY: begin
            if (key_rd_s < m_key_ff) begin
               m_in    = rc[IDX_W-1:0];
               m_id_in = c_id_ff;
            end
            state_in = S_D_DEC;
         end
         S_D_DEC: begin
            slot_we = 1'b1;
            pos_we  = 1'b1;
            if (m_ff == s_ff) begin
               state_in = S_D_END;
            end else begin
               slot_wd  = m_id_ff;
               pos_wa   = m_id_ff;
               s_in     = m_ff;
               state_in = S_D_L;
            end
         end
         S_D_END: begin
            state_in = S_TOP;
            if (act_ff == ACT_BUILD && bidx_ff != '0) begin
               bidx_in  = bidx_ff - 1'b1;
               s_in     = bidx_ff - 1'b1;
               state_in = S_D_SLOT;
            end
         end
         // read back the root for the result
         S_TOP: begin
            slot_ra  = '0;
            state_in = (cnt_ff == '0) ? S_DONE : S_T_ID;
         end
         S_T_ID: begin
            c_id_in  = slot_rd;
            key_ra   = slot_rd;
            state_in = S_T_KEY;
         end
         S_T_KEY: begin
            m_key_in = key_rd_s;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_in.empty_res = (cnt_ff == '0);
               rsp_in.top_id    = (cnt_ff == '0) ? '0 : 6'(c_id_ff);
               rsp_in.top_key   = (cnt_ff == '0) ? '0 : m_key_ff;
               rsp_in.count     = 7'(cnt_ff);
               rsp_in.status    = st_ff;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pres_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pres_ff      <= pres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      st_ff    <= st_in;
      s_ff     <= s_in;
      x_id_ff  <= x_id_in;
      x_key_ff <= x_key_in;
      c_id_ff  <= c_id_in;
      m_ff     <= m_in;
      m_id_ff  <= m_id_in;
      m_key_ff <= m_key_in;
      bidx_ff  <= bidx_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### hw/rtl/imh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
